// File: hdl/assert_macros.svh
// Assertion macros for the string-to-integer parser RTL.
// Both macros expect clk in the including scope; STR2INT_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define STR2INT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STR2INT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STR2INT_ASSERT(lbl, prop, msg)
`define STR2INT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: hdl/str2int_pkg.sv
// Shared types, constants and character helpers for the string-to-integer parser.
// No dependencies.
package str2int_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int CHAR_WIDTH     = 16;
  localparam int POSITION_WIDTH = 16;
  localparam int RADIX_WIDTH    = 6;

  typedef logic [VALUE_WIDTH-1:0]    value_t;
  typedef logic [CHAR_WIDTH-1:0]     char_t;
  typedef logic [POSITION_WIDTH-1:0] pos_t;
  typedef logic [RADIX_WIDTH-1:0]    radix_t;
  typedef logic [5:0]                digit_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    pos_t                          end_offset;
    logic                          found;
  } res_t;

  localparam radix_t RADIX_AUTO  = radix_t'(0);
  localparam radix_t RADIX_OCT   = radix_t'(8);
  localparam radix_t RADIX_DEC   = radix_t'(10);
  localparam radix_t RADIX_HEX   = radix_t'(16);
  localparam radix_t RADIX_MAX   = radix_t'(36);
  localparam radix_t RADIX_RESET = radix_t'(10);

  localparam digit_t NO_DIGIT  = digit_t'(63);
  localparam digit_t DIGIT_TEN = digit_t'(10);

  localparam char_t CH_NUL   = char_t'(0);
  localparam char_t CH_TAB   = char_t'(9);
  localparam char_t CH_CR    = char_t'(13);
  localparam char_t CH_SPACE = char_t'(32);
  localparam char_t CH_MINUS = char_t'(45);
  localparam char_t CH_0     = char_t'(48);
  localparam char_t CH_9     = char_t'(57);
  localparam char_t CH_UA    = char_t'(65);
  localparam char_t CH_UX    = char_t'(88);
  localparam char_t CH_UZ    = char_t'(90);
  localparam char_t CH_LA    = char_t'(97);
  localparam char_t CH_LX    = char_t'(120);
  localparam char_t CH_LZ    = char_t'(122);

  function automatic digit_t digit_of(char_t c);
    digit_t d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = digit_t'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = digit_t'(c - CH_UA) + DIGIT_TEN;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = digit_t'(c - CH_LA) + DIGIT_TEN;
    end
    return d;
  endfunction

  function automatic logic is_space(char_t c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// File: hdl/str2int_ifs.sv
// Valid/ready channel interfaces for the string-to-integer parser.
// Depends on str2int_pkg.
interface str2int_in_if;
  logic                valid;
  logic                ready;
  str2int_pkg::char_t  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface str2int_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [str2int_pkg::VALUE_WIDTH-1:0] value;
  str2int_pkg::pos_t                          end_offset;
  logic                                       found;

  modport source (output valid, output value, output end_offset, output found, input ready);
  modport sink   (input valid, input value, input end_offset, input found, output ready);
endinterface

interface str2int_cfg_if;
  logic                 valid;
  logic                 ready;
  str2int_pkg::radix_t  radix_select;

  modport source (output valid, output radix_select, input ready);
  modport sink   (input valid, input radix_select, output ready);
endinterface

// File: hdl/str2int_core.sv
// Per-character parse step: phase machine, accumulator and positions.
// Depends on str2int_pkg and assert_macros.svh.
`include "assert_macros.svh"

module str2int_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  str2int_pkg::char_t  ch,
  input  str2int_pkg::radix_t cfg_radix,
  output str2int_pkg::res_t   res
);

  typedef enum logic [2:0] {
    PH_START,
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_ZERO_X,
    PH_DIGITS,
    PH_DONE_FOUND,
    PH_DONE_EMPTY
  } phase_t;

  phase_t              phase_r, phase_nxt;
  str2int_pkg::value_t acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  str2int_pkg::radix_t rad_r, rad_nxt;
  str2int_pkg::pos_t   pos_r, pos_nxt;
  str2int_pkg::pos_t   stop_r, stop_nxt;

  str2int_pkg::digit_t d;
  str2int_pkg::radix_t rad_cur;
  logic                found;

  assign d       = str2int_pkg::digit_of(ch);
  assign rad_cur = (phase_r == PH_START) ? cfg_radix : rad_r;

  always_comb begin
    logic                take;
    logic                lead;
    logic                first;
    str2int_pkg::radix_t mul_rad;
    str2int_pkg::value_t mul_acc;
    str2int_pkg::radix_t rad_z;

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    rad_nxt   = rad_r;
    pos_nxt   = pos_r;
    stop_nxt  = stop_r;
    take      = 1'b0;
    lead      = 1'b0;
    first     = 1'b0;
    mul_rad   = rad_r;
    mul_acc   = acc_r;
    rad_z     = rad_r;

    if (step) begin
      if (ch == str2int_pkg::CH_NUL) begin
        phase_nxt = PH_START;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        rad_nxt   = str2int_pkg::RADIX_AUTO;
        pos_nxt   = '0;
        stop_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        unique case (phase_r)
          PH_START: begin
            rad_nxt = cfg_radix;
            if (cfg_radix > str2int_pkg::RADIX_MAX) begin
              phase_nxt = PH_DONE_EMPTY;
            end else begin
              lead = 1'b1;
            end
          end
          PH_WS:     lead  = 1'b1;
          PH_SIGNED: first = 1'b1;
          PH_ZERO: begin
            if (ch == str2int_pkg::CH_LX || ch == str2int_pkg::CH_UX) begin
              phase_nxt = PH_ZERO_X;
            end else begin
              rad_z   = (rad_r == str2int_pkg::RADIX_AUTO) ? str2int_pkg::RADIX_OCT : rad_r;
              rad_nxt = rad_z;
              if (d < rad_z) begin
                take    = 1'b1;
                mul_rad = rad_z;
              end else begin
                phase_nxt = PH_DONE_FOUND;
              end
            end
          end
          PH_ZERO_X: begin
            rad_nxt = str2int_pkg::RADIX_HEX;
            if (d < str2int_pkg::RADIX_HEX) begin
              take    = 1'b1;
              mul_rad = str2int_pkg::RADIX_HEX;
              mul_acc = '0;
            end else begin
              phase_nxt = PH_DONE_FOUND;
            end
          end
          PH_DIGITS: begin
            if (d < rad_r) begin
              take = 1'b1;
            end else begin
              phase_nxt = PH_DONE_FOUND;
            end
          end
          default: ;
        endcase

        if (lead) begin
          if (str2int_pkg::is_space(ch)) begin
            phase_nxt = PH_WS;
          end else if (ch == str2int_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGNED;
          end else begin
            first = 1'b1;
          end
        end

        if (first) begin
          if ((rad_cur == str2int_pkg::RADIX_AUTO || rad_cur == str2int_pkg::RADIX_HEX) &&
              ch == str2int_pkg::CH_0) begin
            acc_nxt   = '0;
            stop_nxt  = pos_r + 1'b1;
            phase_nxt = PH_ZERO;
          end else if (rad_cur == str2int_pkg::RADIX_AUTO) begin
            if (d < str2int_pkg::RADIX_DEC) begin
              rad_nxt = str2int_pkg::RADIX_DEC;
              take    = 1'b1;
              mul_rad = str2int_pkg::RADIX_DEC;
            end else begin
              phase_nxt = PH_DONE_EMPTY;
            end
          end else if (d < rad_cur) begin
            take    = 1'b1;
            mul_rad = rad_cur;
          end else begin
            phase_nxt = PH_DONE_EMPTY;
          end
        end

        if (take) begin
          acc_nxt   = mul_acc * str2int_pkg::value_t'(mul_rad) + str2int_pkg::value_t'(d);
          stop_nxt  = pos_r + 1'b1;
          phase_nxt = PH_DIGITS;
        end
      end
    end
  end

  assign found = (phase_r == PH_ZERO) || (phase_r == PH_ZERO_X) ||
                 (phase_r == PH_DIGITS) || (phase_r == PH_DONE_FOUND);

  always_comb begin
    res.found      = found;
    res.value      = '0;
    res.end_offset = '0;
    if (found) begin
      res.value      = neg_r ? -acc_r : acc_r;
      res.end_offset = stop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      rad_r   <= str2int_pkg::RADIX_AUTO;
      pos_r   <= '0;
      stop_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      rad_r   <= rad_nxt;
      pos_r   <= pos_nxt;
      stop_r  <= stop_nxt;
    end
  end

  `STR2INT_ASSERT(a_start_clean, phase_r == PH_START |-> pos_r == '0 && acc_r == '0 && !neg_r && rad_r == str2int_pkg::RADIX_AUTO, "parse state not clean at string start")
  `STR2INT_ASSERT(a_prefix_radix, phase_r == PH_ZERO_X |-> rad_r == str2int_pkg::RADIX_AUTO || rad_r == str2int_pkg::RADIX_HEX, "0x prefix seen in a radix other than auto or 16")

endmodule

// File: hdl/string_to_integer_parser.sv
// Top level of the string-to-integer parser: channel registers and config register.
// Depends on str2int_pkg, str2int_ifs, str2int_core and assert_macros.svh.
//
// Parses a NUL-terminated string of 16-bit characters, one character per
// transaction on in_chan, as a signed 32-bit integer (strtol style: leading
// white space, optional '-', radix 1..36 or 0 for auto-detect with 0x/0
// prefixes). Each NUL produces one transaction on out_chan with value,
// end_offset and found; other characters produce none. The block takes one
// character per cycle except while a NUL stalls. When the NUL leaves the input
// register, the result of the parse state loads the output register; a parse
// step holds at most a single 32x6 multiply-add. A NUL waits in the input
// register, stalling in_chan, only while an earlier result is not taken. The
// radix register is written over cfg_wr, resets to 10 and is sampled at the
// first character of each string; write it only while no string is in progress.
`include "assert_macros.svh"

module string_to_integer_parser (
  input  logic          clk,
  input  logic          rst_n,
  str2int_in_if.sink    in_chan,
  str2int_out_if.source out_chan,
  str2int_cfg_if.sink   cfg_wr
);

  str2int_pkg::radix_t radix_r;
  str2int_pkg::char_t  in_ch_r;
  logic                in_vld_r;
  str2int_pkg::res_t   out_res_r;
  logic                out_vld_r;
  str2int_pkg::res_t   res;

  logic in_nul;
  logic out_free;
  logic adv;

  assign in_nul   = (in_ch_r == str2int_pkg::CH_NUL);
  assign out_free = !out_vld_r || out_chan.ready;
  assign adv      = in_vld_r && (!in_nul || out_free);

  assign in_chan.ready = !in_vld_r || adv;
  assign cfg_wr.ready  = 1'b1;

  assign out_chan.valid      = out_vld_r;
  assign out_chan.value      = out_res_r.value;
  assign out_chan.end_offset = out_res_r.end_offset;
  assign out_chan.found      = out_res_r.found;

  str2int_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .ch        (in_ch_r),
    .cfg_radix (radix_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= str2int_pkg::RADIX_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        radix_r <= cfg_wr.radix_select;
      end
      if (in_chan.valid && in_chan.ready) begin
        in_vld_r <= 1'b1;
        in_ch_r  <= in_chan.ch;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv && in_nul) begin
        out_vld_r <= 1'b1;
        out_res_r <= res;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  `STR2INT_ASSERT_RST(a_reset_empty, !rst_n |=> !in_vld_r && !out_vld_r, "not empty after reset")
  `STR2INT_ASSERT(a_end_held, in_vld_r && in_nul && !out_free |=> in_vld_r && in_nul, "stalled NUL lost")
  `STR2INT_ASSERT(a_end_result, adv && in_nul |=> out_vld_r, "NUL produced no result")

endmodule

// File: tb/string_to_integer_parser_test.sv
// Self-checking test of string_to_integer_parser: directed and random strings over many radix
// settings, with an internal parse predictor and in-order result comparison.
// Depends on str2int_pkg, str2int_ifs and the parser RTL.
module string_to_integer_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import str2int_pkg::*;

  localparam radix_t RADIX_UNARY     = radix_t'(1);
  localparam radix_t RADIX_BINARY    = radix_t'(2);
  localparam radix_t RADIX_FIRST_BAD = radix_t'(37);
  localparam radix_t RADIX_TOP       = radix_t'(63);
  localparam char_t  CH_HIGH         = char_t'(16'hFFFF);

  localparam int RAND_CHARS     = 1600;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic [2:0] {
    P_START, P_WS, P_SIGNED, P_ZERO, P_ZERO_X, P_DIGITS, P_DONE_FOUND, P_DONE_EMPTY
  } parse_phase_t;

  class parse_tracker;
    radix_t       radix_reg;
    parse_phase_t phase;
    value_t       acc;
    bit           neg;
    int           base;
    pos_t         pos;
    pos_t         stop_pos;
    res_t         parsed_q[$];
    int           errors;
    int           strings;
    int           hits;

    function new();
      radix_reg = RADIX_RESET;
      restart();
    endfunction

    function void restart();
      phase    = P_START;
      acc      = '0;
      neg      = 1'b0;
      base     = 0;
      pos      = '0;
      stop_pos = '0;
    endfunction

    function int digit_val(char_t c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
      if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
      return int'(NO_DIGIT);
    endfunction

    function void take(int d);
      acc      = acc * value_t'(base) + value_t'(d);
      stop_pos = pos + 1'b1;
      phase    = P_DIGITS;
    endfunction

    function void first_digit(char_t c, int d);
      if ((base == RADIX_AUTO || base == RADIX_HEX) && c == CH_0) begin
        acc      = '0;
        stop_pos = pos + 1'b1;
        phase    = P_ZERO;
      end else if (base == RADIX_AUTO) begin
        if (d < RADIX_DEC) begin
          base = RADIX_DEC;
          take(d);
        end else begin
          phase = P_DONE_EMPTY;
        end
      end else if (d < base) begin
        take(d);
      end else begin
        phase = P_DONE_EMPTY;
      end
    endfunction

    function void lead_char(char_t c, int d);
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        phase = P_WS;
      end else if (c == CH_MINUS) begin
        neg   = 1'b1;
        phase = P_SIGNED;
      end else begin
        first_digit(c, d);
      end
    endfunction

    function void note_char(char_t c);
      int   d;
      res_t r;
      if (c == CH_NUL) begin
        r.found      = (phase >= P_ZERO && phase <= P_DONE_FOUND);
        r.value      = r.found ? (neg ? value_t'(-acc) : acc) : '0;
        r.end_offset = r.found ? stop_pos : '0;
        parsed_q.push_back(r);
        strings++;
        if (r.found) hits++;
        restart();
        return;
      end
      d = digit_val(c);
      case (phase)
        P_START: begin
          base = int'(radix_reg);
          if (base > RADIX_MAX) phase = P_DONE_EMPTY;
          else lead_char(c, d);
        end
        P_WS: lead_char(c, d);
        P_SIGNED: first_digit(c, d);
        P_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            phase = P_ZERO_X;
          end else begin
            if (base == RADIX_AUTO) base = RADIX_OCT;
            if (d < base) take(d);
            else phase = P_DONE_FOUND;
          end
        end
        P_ZERO_X: begin
          base = RADIX_HEX;
          if (d < RADIX_HEX) begin
            acc = '0;
            take(d);
          end else begin
            phase = P_DONE_FOUND;
          end
        end
        P_DIGITS: begin
          if (d < base) take(d);
          else phase = P_DONE_FOUND;
        end
        default: ;
      endcase
      pos = pos + 1'b1;
    endfunction

    function void check_result(logic signed [VALUE_WIDTH-1:0] v, pos_t off, logic f);
      res_t e;
      if (parsed_q.size() == 0) begin
        $error("unexpected transaction: value %0d end_offset %0d found %0b", v, off, f);
        errors++;
        return;
      end
      e = parsed_q.pop_front();
      if (v !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, v);
        errors++;
      end
      if (off !== e.end_offset) begin
        $error("end_offset: expected %0d, got %0d", e.end_offset, off);
        errors++;
      end
      if (f !== e.found) begin
        $error("found: expected %0b, got %0b", e.found, f);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  str2int_in_if  in_if();
  str2int_out_if out_if();
  str2int_cfg_if cfg_if();

  string_to_integer_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_wr   (cfg_if)
  );

  parse_tracker tracker = new();
  char_t        text[$];
  bit           sender_idle;
  bit           recv_idle;
  bit           hold_request;
  int           sent_chars;
  int           radix_writes;
  int           stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  function char_t digit_char(int d);
    if (d < 10) return char_t'(CH_0 + d);
    return char_t'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10);
  endfunction

  function char_t blank_char();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return char_t'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function char_t rand_char();
    string marks;
    marks = " \t-+xX0";
    case ($urandom_range(0, 3))
      0: return char_t'($urandom_range(1, 65535));
      1: return char_t'(marks[$urandom_range(0, marks.len() - 1)]);
      2: return char_t'($urandom_range(33, 126));
      default: return digit_char($urandom_range(0, 35));
    endcase
  endfunction

  // mostly well-formed numbers with random content; the rest is noise
  function void compose_text(int r);
    int n;
    int d;
    int eff;
    int pfx;
    text.delete();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(0, 8);
      repeat (n) text.push_back(rand_char());
      return;
    end
    n = $urandom_range(0, 3);
    repeat (n) text.push_back(blank_char());
    if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
    eff = (r > RADIX_MAX) ? int'(RADIX_MAX) : r;
    pfx = $urandom_range(0, 3);
    if (pfx == 1) begin
      text.push_back(CH_0);
      text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      if (r == RADIX_AUTO) eff = RADIX_HEX;
    end else if (pfx == 2) begin
      text.push_back(CH_0);
      if (r == RADIX_AUTO) eff = RADIX_OCT;
    end
    if (eff == 0) eff = RADIX_DEC;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    repeat (n) begin
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35) : $urandom_range(0, eff - 1);
      text.push_back(digit_char(d));
    end
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) text.push_back(rand_char());
    end
  endfunction

  function radix_t pick_radix(int k);
    case (k)
      0: return RADIX_AUTO;
      1: return RADIX_UNARY;
      2: return RADIX_BINARY;
      3: return RADIX_OCT;
      4: return RADIX_DEC;
      5: return RADIX_HEX;
      6: return RADIX_MAX;
      7: return RADIX_FIRST_BAD;
      8: return RADIX_TOP;
      default: return radix_t'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_char(char_t c);
    int gap;
    gap = sender_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_char(c);
    sent_chars++;
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  task automatic send_ascii(string s);
    for (int i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
    send_char(CH_NUL);
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i]);
    send_char(CH_NUL);
  endtask

  task automatic wait_quiet();
    stop_sending();
    while (tracker.parsed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(radix_t r);
    wait_quiet();
    cfg_if.valid        <= 1'b1;
    cfg_if.radix_select <= r;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tracker.radix_reg = r;
    radix_writes++;
  endtask

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      tracker.check_result(out_if.value, out_if.end_offset, out_if.found);
    end
  end

  initial begin
    int phase_no;
    int start_chars;
    int n_strings;
    radix_t r;
    in_if.valid         <= 1'b0;
    in_if.ch            <= CH_NUL;
    cfg_if.valid        <= 1'b0;
    cfg_if.radix_select <= RADIX_RESET;
    sender_idle  = 1'b1;
    recv_idle    = 1'b1;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset radix first, then auto, unary, invalid and the top radix
    send_ascii("\t-9z");
    send_char(CH_HIGH);
    send_char(CH_NUL);
    write_radix(RADIX_AUTO);
    send_ascii("-0x1A");
    send_ascii("0xg");
    send_ascii("08");
    write_radix(RADIX_UNARY);
    send_ascii("00");
    write_radix(RADIX_TOP);
    send_ascii("5");
    write_radix(RADIX_MAX);
    send_ascii("zZ");

    start_chars = sent_chars;
    phase_no    = 0;
    while (sent_chars - start_chars < RAND_CHARS) begin
      r = pick_radix(phase_no);
      write_radix(r);
      sender_idle = ($urandom_range(0, 3) != 0);
      recv_idle   = ($urandom_range(0, 3) != 0);
      if (phase_no == 2) begin
        sender_idle  = 1'b0;
        hold_request = 1'b1;
      end
      n_strings = $urandom_range(10, 25);
      repeat (n_strings) begin
        compose_text(int'(r));
        send_text();
      end
      phase_no++;
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("Parsed %0d strings (%0d with digits) from %0d characters", tracker.strings,
             tracker.hits, sent_chars);
    $display("Radix register written %0d times over %0d random phases", radix_writes, phase_no);
    if (tracker.errors == 0 && tracker.parsed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/str2int_pkg.sv
hdl/str2int_ifs.sv
hdl/str2int_core.sv
hdl/string_to_integer_parser.sv
tb/string_to_integer_parser_test.sv
